// ===== rtl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants of the glob matcher
// Pattern byte codes, register indexes and the records passed along the
// row of position cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int unsigned STORED_BYTES = 32;
  localparam int unsigned CFG_WORDS    = 4;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned LEN_W        = 6;

  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [7:0] QMARK_CODE = 8'h3F;
  localparam logic [7:0] NUL_CODE   = 8'h00;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_WORD_0 = 3'd0,
    CFG_PATTERN_WORD_1 = 3'd1,
    CFG_PATTERN_WORD_2 = 3'd2,
    CFG_PATTERN_WORD_3 = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } cfg_index_t;

  // Per-position view of the pattern, prepared by the config stage.
  typedef struct packed {
    logic [7:0] pat;   // pattern byte
    logic       en;    // position lies below the effective length
    logic       star;  // enabled '*'
  } wgm_pos_t;

  // What a cell hands to its right neighbor.
  typedef struct packed {
    logic adv;    // byte consumed: next position becomes active
    logic carry;  // closed bit behind a '*': empty run reaches next position
  } wgm_link_t;

endpackage

// ===== rtl/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position of the matcher
// Advances its active bit over one subject byte and forwards the star
// closure to the next position.
// ----------------------------------------------------------------------------
module wgm_cell (
  input  wgm_pkg::wgm_pos_t  pos,
  input  logic [7:0]         subj,
  input  logic               step,     // 1: consume subj, 0: only re-close
  input  logic               active,   // this position active before the step
  input  logic               keep,     // position within the length mask
  input  wgm_pkg::wgm_link_t link_in,
  output wgm_pkg::wgm_link_t link_out,
  output logic               closed    // this position active after the step
);
  import wgm_pkg::*;

  logic stay;
  logic hit;
  logic n_bit;

  assign hit  = (pos.pat == QMARK_CODE) || (pos.pat == subj);
  assign stay = step ? (active & pos.star) : (active & keep);

  assign n_bit  = stay | link_in.adv;
  assign closed = n_bit | link_in.carry;

  assign link_out.adv   = step & active & pos.en & ~pos.star & hit;
  assign link_out.carry = closed & pos.star;

endmodule

// ===== rtl/wgm_cfg.sv =====
// ----------------------------------------------------------------------------
// wgm_cfg: pattern registers and derived per-position setup
// Holds the written words and length, finds the effective length and
// registers the position records, masks and start set after each write.
// ----------------------------------------------------------------------------
module wgm_cfg #(
  parameter int unsigned NCELL = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wgm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output wgm_pkg::wgm_pos_t                   pos_r [NCELL],
  output logic [NCELL:0]                      mask_r,
  output logic [NCELL:0]                      lenhot_r,
  output logic [NCELL:0]                      init_r,
  output logic                                busy,
  output logic                                reclose
);
  import wgm_pkg::*;

  logic [CFG_DATA_W-1:0]       word_r [CFG_WORDS];
  logic [LEN_W-1:0]            len_r;
  logic [1:0]                  settle_r;
  logic [1:0]                  settle_nxt;
  logic [8*STORED_BYTES-1:0]   pat_bits;
  logic [LEN_W-1:0]            lim;
  logic [NCELL-1:0]            en;
  wgm_pos_t                    pos_nxt [NCELL];
  logic [NCELL:0]              mask_nxt;
  logic [NCELL:0]              lenhot_nxt;
  logic [NCELL:0]              init_nxt;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CFG_WORDS; k++) word_r[k] <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_WORD_0: word_r[0] <= cfg_data;
        CFG_PATTERN_WORD_1: word_r[1] <= cfg_data;
        CFG_PATTERN_WORD_2: word_r[2] <= cfg_data;
        CFG_PATTERN_WORD_3: word_r[3] <= cfg_data;
        CFG_PATTERN_LENGTH: len_r     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // settle counter: derive position records, then start set and re-close
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we)                settle_nxt = 2'd2;
    else if (settle_r != 2'd0) settle_nxt = settle_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= 2'd2;
    else        settle_r <= settle_nxt;
  end

  assign busy    = (settle_r != 2'd0);
  assign reclose = (settle_r == 2'd1);

  assign pat_bits = {word_r[3], word_r[2], word_r[1], word_r[0]};
  assign lim      = (len_r > LEN_W'(NCELL)) ? LEN_W'(NCELL) : len_r;

  // effective length: the written length, capped at NCELL, stopping at the first NUL byte
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      en[i] = (LEN_W'(i) < lim) && (pat_bits[8*i +: 8] != NUL_CODE);
      if (i > 0) en[i] = en[i] & en[i-1];
    end
  end

  always_comb begin
    mask_nxt[0] = 1'b1;
    for (int i = 0; i < NCELL; i++) begin
      pos_nxt[i].pat  = pat_bits[8*i +: 8];
      pos_nxt[i].en   = en[i];
      pos_nxt[i].star = en[i] && (pat_bits[8*i +: 8] == STAR_CODE);
      mask_nxt[i+1]   = en[i];
    end
    for (int j = 0; j < NCELL; j++) lenhot_nxt[j] = mask_nxt[j] & ~mask_nxt[j+1];
    lenhot_nxt[NCELL] = mask_nxt[NCELL];
  end

  // start set: position zero plus whatever a leading run of stars reaches
  always_comb begin
    init_nxt[0] = 1'b1;
    for (int i = 0; i < NCELL; i++) init_nxt[i+1] = init_nxt[i] & pos_r[i].star;
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    mask_r   <= mask_nxt;
    lenhot_r <= lenhot_nxt;
    init_r   <= init_nxt;
  end

endmodule

// ===== rtl/wildcard_glob_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit: streamed glob matcher with '*' and '?'
// Keeps one active bit per pattern position and advances all of them per
// subject byte through a row of position cells.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write the four pattern words and the length (indexes 0..4) while
//            the unit is idle. After each write in_ready drops while the setup
//            stage rebuilds the position records and re-closes the active
//            set; writes are taken at any time.
//   in_*   : one subject byte per transfer. A transfer with in_has_byte low,
//            or with in_end_of_string high, ends the string.
//   out_*  : one transfer per string, out_matched high on a full match.
// Throughput: one byte per cycle while in_ready is high, set by the single
//   pass of the byte through the cell row (compare, advance, star closure).
// Result: the match of the ending input transfer is registered into the output register.
// Reset: pattern cleared (empty pattern), active set at position zero;
//   in_ready stays low after reset until the setup stage has settled.
// Stall: while a result waits and out_ready is low, in_ready is low; when
//   out_ready is high and setup is not busy the next byte is taken in the same cycle.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit #(
  parameter int unsigned MAX_PATTERN_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [wgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // subject bytes
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_subject_byte,
  input  logic                              in_has_byte,
  input  logic                              in_end_of_string,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_matched
);
  import wgm_pkg::*;

  // Positions beyond the stored bytes can never be used.
  localparam int unsigned NCELL = (MAX_PATTERN_LEN < STORED_BYTES) ?
                                  MAX_PATTERN_LEN : STORED_BYTES;

  wgm_pos_t         pos_r [NCELL];
  logic [NCELL:0]   mask_r;
  logic [NCELL:0]   lenhot_r;
  logic [NCELL:0]   init_r;
  logic             busy;
  logic             reclose;

  // raw_r: active set as left by the last byte (closed under the pattern of
  // that time). work_r: the same set masked and closed under the current
  // pattern, ready for the next byte.
  logic [NCELL:0]   raw_r,  raw_nxt;
  logic [NCELL:0]   work_r, work_nxt;
  logic             out_valid_r,   out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;

  logic [NCELL:0]   chain_in;
  logic [NCELL:0]   next_set;
  logic             step;
  logic             in_xfer;
  logic             is_end;
  logic             top_bit;
  wgm_link_t        link [NCELL];

  wgm_cfg #(
    .NCELL (NCELL)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_r     (pos_r),
    .mask_r    (mask_r),
    .lenhot_r  (lenhot_r),
    .init_r    (init_r),
    .busy      (busy),
    .reclose   (reclose)
  );

  // A re-close pass after a write feeds the raw set through the row without
  // consuming a byte; a byte-less item likewise only masks and re-closes the set.
  assign chain_in = reclose ? raw_r : work_r;
  assign step     = ~reclose & in_has_byte;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wgm_link_t link_in;
    if (i == 0) begin : g_head
      assign link_in = '0;
    end else begin : g_body
      assign link_in = link[i-1];
    end
    wgm_cell u_cell (
      .pos      (pos_r[i]),
      .subj     (in_subject_byte),
      .step     (step),
      .active   (chain_in[i]),
      .keep     (mask_r[i]),
      .link_in  (link_in),
      .link_out (link[i]),
      .closed   (next_set[i])
    );
  end

  // Top position has no pattern byte of its own: it only collects.
  assign top_bit         = ~step & chain_in[NCELL] & mask_r[NCELL];
  assign next_set[NCELL] = top_bit | link[NCELL-1].adv | link[NCELL-1].carry;

  assign in_ready = ~busy & (~out_valid_r | out_ready);
  assign in_xfer  = in_valid & in_ready;
  assign is_end   = ~in_has_byte | in_end_of_string;

  always_comb begin
    raw_nxt         = raw_r;
    work_nxt        = work_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_matched_nxt = out_matched_r;
    priority if (in_xfer) begin
      if (is_end) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = |(next_set & lenhot_r);
        raw_nxt         = (NCELL+1)'(1);
        work_nxt        = init_r;
      end else begin
        raw_nxt  = next_set;
        work_nxt = next_set;
      end
    end else if (reclose) begin
      work_nxt = next_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r       <= (NCELL+1)'(1);
      work_r      <= (NCELL+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      raw_r       <= raw_nxt;
      work_r      <= work_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

`ifndef ASSERT_OFF
  // no byte enters while the setup stage is still settling
  a_no_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("input transfer allowed during setup");

  // a held result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result is stalled");

  // the working set never holds positions past the pattern length
  a_set_masked: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ((work_r & ~mask_r) == '0))
    else $error("active position beyond pattern length");

  // the end of a string restarts the search from the start set
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_end) |=> (out_valid_r && raw_r == (NCELL+1)'(1) &&
                             work_r == init_r))
    else $error("search not restarted after string end");

  // a result appears only after an ending transfer
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_xfer && is_end))
    else $error("result without string end");
`endif

endmodule
